/* hdl/pptfc_pkg.sv */
// Package for the pre/post-trigger fault capture block.
// Holds field widths, register indexes and parameter defaults; depends on nothing.
package pptfc_pkg;

  // Field widths fixed by the interface.
  localparam int DataW     = 48;
  localparam int FaultW    = 16;
  localparam int SlotW     = 13;
  localparam int PosW      = 5;
  localparam int TicksW    = 5;
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 13;
  localparam int NumSources = 5;

  // Defaults for the top-level parameters.
  localparam int HistoryDepthDef = 30;
  localparam int CaptureCountDef = 200;
  localparam int PayloadBitsDef  = 48;

  // Register reset values.
  localparam logic [TicksW-1:0] PostTicksReset = 5'd16;
  localparam logic [SlotW-1:0]  StartSlotReset = 13'd0;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegPostTriggerTicks = 2'd0;
  localparam logic [CfgIdxW-1:0] RegStartSlot        = 2'd1;

endpackage

/* hdl/pptfc_cell.sv */
// One history cell of the capture chain: a payload register that takes either
// its neighbor's entry or a fresh sample. Depends on nothing.
module pptfc_cell #(
  parameter int Width = 48
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             shift_i,
  input  logic             take_sample_i,
  input  logic [Width-1:0] sample_i,
  input  logic [Width-1:0] neighbor_i,
  output logic [Width-1:0] data_o
);

  logic [Width-1:0] data_q;
  logic [Width-1:0] data_d;

  // Pick the incoming entry: a new sample at the head, otherwise the neighbor.
  always_comb begin
    data_d = data_q;
    if (shift_i) begin
      data_d = take_sample_i ? sample_i : neighbor_i;
    end
  end

  // History storage starts at zero after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_q <= '0;
    end else begin
      data_q <= data_d;
    end
  end

  assign data_o = data_q;

endmodule

/* hdl/pptfc_trigger.sv */
// Fault trigger detection: compares each fault word with its value on the
// previous tick. Depends on pptfc_pkg.
module pptfc_trigger (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        tick_i,
  input  logic [pptfc_pkg::FaultW-1:0] fault_i [pptfc_pkg::NumSources],
  output logic                        trigger_o
);

  logic [pptfc_pkg::FaultW-1:0] prev_q [pptfc_pkg::NumSources];
  logic [pptfc_pkg::NumSources-1:0] hit;

  // A source fires when its word is nonzero and has changed since last tick.
  always_comb begin
    for (int i = 0; i < pptfc_pkg::NumSources; i++) begin
      hit[i] = (fault_i[i] != '0) && (fault_i[i] != prev_q[i]);
    end
  end

  assign trigger_o = |hit;

  // Remember this tick's fault words.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < pptfc_pkg::NumSources; i++) begin
        prev_q[i] <= '0;
      end
    end else if (tick_i) begin
      for (int i = 0; i < pptfc_pkg::NumSources; i++) begin
        prev_q[i] <= fault_i[i];
      end
    end
  end

endmodule

/* hdl/pre_post_trigger_fault_capture.sv */
// Top level of the pre/post-trigger fault capture block; uses pptfc_pkg,
// pptfc_cell and pptfc_trigger. Each accepted tick enters its snapshot into a
// chain of HISTORY_DEPTH cells and has its fault words checked for triggers.
// When the post-trigger count reaches post_trigger_ticks, the chain rotates
// once, one cell per cycle while the output register is free or being taken,
// and each rotation step hands the oldest entry to the output register; no
// tick is accepted during the dump. The last record waits in the output
// register while the next tick is already accepted. Configuration writes are
// taken at any time and should only be issued while the block is idle; there
// is no clearing pass.
module pre_post_trigger_fault_capture #(
  parameter int HISTORY_DEPTH = pptfc_pkg::HistoryDepthDef,
  parameter int CAPTURE_COUNT = pptfc_pkg::CaptureCountDef,
  parameter int PAYLOAD_BITS  = pptfc_pkg::PayloadBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Input tick channel.
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [pptfc_pkg::DataW-1:0]   sample_payload_i,
  input  logic [pptfc_pkg::FaultW-1:0]  system_fault_i,
  input  logic [pptfc_pkg::FaultW-1:0]  supply_a_fault_i,
  input  logic [pptfc_pkg::FaultW-1:0]  supply_b_fault_i,
  input  logic [pptfc_pkg::FaultW-1:0]  inverter_a_fault_i,
  input  logic [pptfc_pkg::FaultW-1:0]  inverter_b_fault_i,
  // Record output channel.
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [pptfc_pkg::DataW-1:0]   record_data_o,
  output logic [pptfc_pkg::SlotW-1:0]   record_slot_o,
  output logic [pptfc_pkg::PosW-1:0]    record_position_o,
  output logic                          capture_last_o,
  // Configuration write channel.
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [pptfc_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [pptfc_pkg::CfgDataW-1:0] cfg_data_i
);

  localparam int CellW     = (PAYLOAD_BITS < pptfc_pkg::DataW) ? PAYLOAD_BITS
                                                                : pptfc_pkg::DataW;
  localparam int SlotTotal = CAPTURE_COUNT * HISTORY_DEPTH;
  localparam int SlotCntW  = $clog2(SlotTotal);
  localparam int IdxW      = $clog2(HISTORY_DEPTH);

  localparam logic [SlotCntW-1:0] SlotLast = SlotCntW'(SlotTotal - 1);
  localparam logic [IdxW-1:0]     IdxLast  = IdxW'(HISTORY_DEPTH - 1);

  // Configuration and control state.
  logic [pptfc_pkg::TicksW-1:0] post_ticks_q;
  logic [SlotCntW-1:0]          write_slot_q, write_slot_d;
  logic                         armed_q, armed_d;
  logic [pptfc_pkg::TicksW-1:0] post_count_q, post_count_d;
  logic                         dump_q, dump_d;
  logic [IdxW-1:0]              idx_q, idx_d;

  // Output register.
  logic                         out_valid_q, out_valid_d;
  logic [pptfc_pkg::DataW-1:0]  rec_data_q;
  logic [pptfc_pkg::SlotW-1:0]  rec_slot_q;
  logic [pptfc_pkg::PosW-1:0]   rec_pos_q;
  logic                         rec_last_q;

  logic                         tick;
  logic                         load;
  logic                         shift;
  logic                         trigger;
  logic                         cfg_write;
  logic [pptfc_pkg::TicksW-1:0] count_base;
  logic [pptfc_pkg::TicksW-1:0] count_next;
  logic [pptfc_pkg::FaultW-1:0] faults [pptfc_pkg::NumSources];
  logic [CellW-1:0]             sample;
  logic [CellW-1:0]             cell_data [HISTORY_DEPTH];

  assign in_ready_o  = !dump_q;
  assign tick        = in_valid_i && in_ready_o;
  assign load        = dump_q && (!out_valid_q || out_ready_i);
  assign shift       = tick || load;
  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;
  assign sample      = CellW'(sample_payload_i);

  assign faults[0] = system_fault_i;
  assign faults[1] = supply_a_fault_i;
  assign faults[2] = supply_b_fault_i;
  assign faults[3] = inverter_a_fault_i;
  assign faults[4] = inverter_b_fault_i;

  pptfc_trigger u_trigger (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .tick_i    (tick),
    .fault_i   (faults),
    .trigger_o (trigger)
  );

  // History chain: the newest entry sits in the last cell. During a dump the
  // chain rotates so the oldest entry in cell 0 wraps round to the last cell.
  for (genvar g = 0; g < HISTORY_DEPTH; g++) begin : g_cells
    if (g == HISTORY_DEPTH - 1) begin : g_head
      pptfc_cell #(.Width(CellW)) u_cell (
        .clk_i         (clk_i),
        .rst_ni        (rst_ni),
        .shift_i       (shift),
        .take_sample_i (tick),
        .sample_i      (sample),
        .neighbor_i    (cell_data[0]),
        .data_o        (cell_data[g])
      );
    end else begin : g_body
      pptfc_cell #(.Width(CellW)) u_cell (
        .clk_i         (clk_i),
        .rst_ni        (rst_ni),
        .shift_i       (shift),
        .take_sample_i (1'b0),
        .sample_i      (sample),
        .neighbor_i    (cell_data[g+1]),
        .data_o        (cell_data[g])
      );
    end
  end

  // Post-trigger counting: a trigger restarts the count at this tick.
  assign count_base = trigger ? '0 : post_count_q;
  assign count_next = count_base + pptfc_pkg::TicksW'(1);

  always_comb begin
    armed_d      = armed_q;
    post_count_d = post_count_q;
    dump_d       = dump_q;
    idx_d        = idx_q;
    write_slot_d = write_slot_q;
    if (tick) begin
      if (armed_q || trigger) begin
        if (count_next >= post_ticks_q) begin
          armed_d      = 1'b0;
          post_count_d = '0;
          dump_d       = 1'b1;
          idx_d        = '0;
        end else begin
          armed_d      = 1'b1;
          post_count_d = count_next;
        end
      end
    end
    if (load) begin
      idx_d        = idx_q + IdxW'(1);
      write_slot_d = (write_slot_q == SlotLast) ? '0 : write_slot_q + SlotCntW'(1);
      if (idx_q == IdxLast) begin
        dump_d = 1'b0;
      end
    end
    // A start slot write reloads the slot counter; a value beyond the slot range gives slot 0.
    if (cfg_write && (cfg_index_i == pptfc_pkg::RegStartSlot)) begin
      write_slot_d = (32'(cfg_data_i) < SlotTotal) ? SlotCntW'(cfg_data_i) : '0;
    end
  end

  // Output register handshake.
  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      post_ticks_q <= pptfc_pkg::PostTicksReset;
      write_slot_q <= SlotCntW'(pptfc_pkg::StartSlotReset);
      armed_q      <= 1'b0;
      post_count_q <= '0;
      dump_q       <= 1'b0;
      idx_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_write && (cfg_index_i == pptfc_pkg::RegPostTriggerTicks)) begin
        post_ticks_q <= cfg_data_i[pptfc_pkg::TicksW-1:0];
      end
      write_slot_q <= write_slot_d;
      armed_q      <= armed_d;
      post_count_q <= post_count_d;
      dump_q       <= dump_d;
      idx_q        <= idx_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Record payload, loaded from the oldest cell on each dump step.
  always_ff @(posedge clk_i) begin
    if (load) begin
      rec_data_q <= pptfc_pkg::DataW'(cell_data[0]);
      rec_slot_q <= pptfc_pkg::SlotW'(write_slot_q);
      rec_pos_q  <= pptfc_pkg::PosW'(idx_q);
      rec_last_q <= (idx_q == IdxLast);
    end
  end

  assign out_valid_o       = out_valid_q;
  assign record_data_o     = rec_data_q;
  assign record_slot_o     = rec_slot_q;
  assign record_position_o = rec_pos_q;
  assign capture_last_o    = rec_last_q;

`ifndef SYNTH
  // The final record of a dump is always at the last history position.
  a_last_position: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && capture_last_o) |-> (record_position_o == pptfc_pkg::PosW'(IdxLast)))
    else $error("capture_last on a record that is not the newest entry");

  // A record that is not taken stays valid and unchanged.
  a_hold_record: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(record_data_o)
      && $stable(record_slot_o) && $stable(record_position_o)
      && $stable(capture_last_o)))
    else $error("record changed or dropped before its transfer");

  // A tick is never accepted in the same cycle as a dump step.
  a_no_tick_in_dump: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick |-> !load)
    else $error("tick accepted during a dump step");

  // Slot numbers stay within the slot range.
  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (32'(record_slot_o) < SlotTotal))
    else $error("record slot beyond the slot range");
`endif

endmodule
